### src/fdes_pkg.sv
// fdes_pkg: shared types and constants for the directory entry scanner
// used by fdes_entry_parse and fat_directory_entry_scanner, no dependencies
package fdes_pkg;

    localparam int POS_W      = 5;
    localparam int NAME_BYTES = 11;
    localparam int TARGET_W   = 8 * NAME_BYTES;

    // byte positions inside a 32-byte entry
    localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
    localparam logic [POS_W-1:0] POS_ATTR      = 5'd11;
    localparam logic [POS_W-1:0] POS_CLUS_HI_0 = 5'd20;
    localparam logic [POS_W-1:0] POS_CLUS_HI_1 = 5'd21;
    localparam logic [POS_W-1:0] POS_CLUS_LO_0 = 5'd26;
    localparam logic [POS_W-1:0] POS_CLUS_LO_1 = 5'd27;
    localparam logic [POS_W-1:0] POS_SIZE_0    = 5'd28;
    localparam logic [POS_W-1:0] POS_LAST      = 5'd31;

    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam logic [7:0] MARK_END       = 8'h00;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;

    // result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // configuration register indexes (8-byte stride)
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_HEAD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_TAIL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIND_MODE   = 2'd2;
    localparam int ADDR_W = REG_IDX_W + 3;

    typedef logic [NAME_BYTES-1:0][7:0] name_bytes_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] name_head;
        logic [23:0] name_tail;
        logic [7:0]  attribute_bits;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic        name_matches;
        logic        scan_stopped;
    } result_t;

endpackage

### src/fdes_entry_parse.sv
// fdes_entry_parse: per-byte entry position tracking, field capture and result build
// depends on fdes_pkg
module fdes_entry_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_accept,
    input  logic [7:0]                    data_byte,
    input  logic                          scan_start,
    input  logic [fdes_pkg::TARGET_W-1:0] target_name,
    input  logic                          find_mode,
    output logic                          res_valid,
    output fdes_pkg::result_t             res
);

    logic [fdes_pkg::POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic                       stopped_reg, stopped_next, stopped_cur;
    logic                       skipping_reg, skipping_next, skip_cur;

    fdes_pkg::name_bytes_t name_reg, name_next;
    logic [7:0]            attr_reg, attr_next;
    logic [15:0]           clus_hi_reg, clus_hi_next;
    logic [15:0]           clus_lo_reg, clus_lo_next;
    logic [3:0][7:0]       size_reg, size_next;

    logic active, is_end, keep, emit_entry, match;

    assign pos_cur     = scan_start ? fdes_pkg::POS_FIRST : pos_reg;
    assign stopped_cur = scan_start ? 1'b0 : stopped_reg;
    assign active      = byte_accept && !stopped_cur;
    assign is_end      = (pos_cur == fdes_pkg::POS_FIRST) && (data_byte == fdes_pkg::MARK_END);
    assign skip_cur    = (pos_cur == fdes_pkg::POS_FIRST)
                         ? ((data_byte == fdes_pkg::MARK_DELETED) || is_end)
                         : skipping_reg;
    assign keep        = active && !skip_cur;
    assign emit_entry  = keep && (pos_cur == fdes_pkg::POS_LAST);
    assign match       = (name_reg == target_name);

    always_comb
    begin
        name_next     = name_reg;
        attr_next     = attr_reg;
        clus_hi_next  = clus_hi_reg;
        clus_lo_next  = clus_lo_reg;
        size_next     = size_reg;
        skipping_next = skipping_reg;
        pos_next      = pos_reg;
        stopped_next  = stopped_reg;
        if (byte_accept)
        begin
            pos_next     = pos_cur;
            stopped_next = stopped_cur;
        end
        if (active)
        begin
            pos_next = pos_cur + 1'b1;
            if (pos_cur == fdes_pkg::POS_FIRST)
                skipping_next = skip_cur;
            if (is_end || (emit_entry && match && find_mode))
                stopped_next = 1'b1;
        end
        if (keep)
        begin
            for (int k = 0; k < fdes_pkg::NAME_BYTES; k++)
            begin
                if (pos_cur == fdes_pkg::POS_W'(k))
                    name_next[k] = data_byte;
            end
            if (pos_cur == fdes_pkg::POS_ATTR)
            begin
                attr_next     = data_byte;
                skipping_next = (data_byte == fdes_pkg::ATTR_LONG_NAME);
            end
            if (pos_cur == fdes_pkg::POS_CLUS_HI_0)
                clus_hi_next[7:0] = data_byte;
            if (pos_cur == fdes_pkg::POS_CLUS_HI_1)
                clus_hi_next[15:8] = data_byte;
            if (pos_cur == fdes_pkg::POS_CLUS_LO_0)
                clus_lo_next[7:0] = data_byte;
            if (pos_cur == fdes_pkg::POS_CLUS_LO_1)
                clus_lo_next[15:8] = data_byte;
            // positions 28..31 map to size bytes 0..3 by their low bits
            if (pos_cur >= fdes_pkg::POS_SIZE_0)
                size_next[pos_cur[1:0]] = data_byte;
        end
    end

    always_comb
    begin
        res_valid = active && (is_end || emit_entry);
        res       = '0;
        if (is_end)
        begin
            res.kind         = fdes_pkg::KIND_END;
            res.scan_stopped = 1'b1;
        end
        else
        begin
            res.kind           = fdes_pkg::KIND_ENTRY;
            res.name_head      = name_reg[7:0];
            res.name_tail      = name_reg[10:8];
            res.attribute_bits = attr_reg;
            res.first_cluster  = {clus_hi_reg, clus_lo_reg};
            // last size byte arrives with this request
            res.file_size      = {data_byte, size_reg[2], size_reg[1], size_reg[0]};
            res.name_matches   = match;
            res.scan_stopped   = match && find_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            stopped_reg  <= 1'b0;
            skipping_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            stopped_reg  <= stopped_next;
            skipping_reg <= skipping_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg    <= name_next;
        attr_reg    <= attr_next;
        clus_hi_reg <= clus_hi_next;
        clus_lo_reg <= clus_lo_next;
        size_reg    <= size_next;
    end

    a_end_at_first: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == fdes_pkg::KIND_END) |-> pos_cur == fdes_pkg::POS_FIRST)
        else $error("end marker reported away from entry start");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && !scan_start && stopped_reg |=> $stable(pos_reg) && stopped_reg)
        else $error("stopped scan advanced");

endmodule

### src/fat_directory_entry_scanner.sv
// fat_directory_entry_scanner: top level, config registers and two-deep result queue
// depends on fdes_pkg and fdes_entry_parse
//
//  channel   | signals                                 | role
//  ----------+-----------------------------------------+-------------------------
//  byte      | byte_valid, byte_stall, data_byte,      | one directory byte in
//            | scan_start                              |
//  result    | result_valid, result_stall, kind, ...   | entry or end-of-dir out
//  config    | psel, penable, pwrite, paddr, pwdata,   | target name, find mode
//            | prdata, pready                          |
//
// one byte per cycle while byte_stall is low; each result is registered in the output register or skid slot
// the byte side stalls only while the result register and its skid slot are both full
// reset clears position, stop flag, config registers and queue valids
// registers sit at byte addresses 0, 8 and 16, 64-bit data
module fat_directory_entry_scanner (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        scan_start,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        kind,
    output logic [63:0]                 name_head,
    output logic [23:0]                 name_tail,
    output logic [7:0]                  attribute_bits,
    output logic [31:0]                 first_cluster,
    output logic [31:0]                 file_size,
    output logic                        name_matches,
    output logic                        scan_stopped,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdes_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    logic [63:0] head_reg;
    logic [23:0] tail_reg;
    logic        find_reg;

    logic                           cfg_write;
    logic [fdes_pkg::REG_IDX_W-1:0] reg_idx;

    logic              byte_accept, out_take, out_free;
    logic              par_valid;
    fdes_pkg::result_t par_res;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    fdes_pkg::result_t out_reg, out_next;
    fdes_pkg::result_t skid_reg, skid_next;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[fdes_pkg::ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            fdes_pkg::REG_TARGET_HEAD: prdata = head_reg;
            fdes_pkg::REG_TARGET_TAIL: prdata = {40'd0, tail_reg};
            fdes_pkg::REG_FIND_MODE:   prdata = {63'd0, find_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            find_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                fdes_pkg::REG_TARGET_HEAD: head_reg <= pwdata;
                fdes_pkg::REG_TARGET_TAIL: tail_reg <= pwdata[23:0];
                fdes_pkg::REG_FIND_MODE:   find_reg <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    assign byte_stall  = skid_valid_reg;
    assign byte_accept = byte_valid && !byte_stall;

    fdes_entry_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (data_byte),
        .scan_start  (scan_start),
        .target_name ({tail_reg, head_reg}),
        .find_mode   (find_reg),
        .res_valid   (par_valid),
        .res         (par_res)
    );

    assign out_take = out_valid_reg && !result_stall;
    assign out_free = !out_valid_reg || out_take;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (par_valid)
            begin
                out_valid_next = 1'b1;
                out_next       = par_res;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (par_valid)
        begin
            // output held downstream, park the new result
            skid_valid_next = 1'b1;
            skid_next       = par_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid   = out_valid_reg;
    assign kind           = out_reg.kind;
    assign name_head      = out_reg.name_head;
    assign name_tail      = out_reg.name_tail;
    assign attribute_bits = out_reg.attribute_bits;
    assign first_cluster  = out_reg.first_cluster;
    assign file_size      = out_reg.file_size;
    assign name_matches   = out_reg.name_matches;
    assign scan_stopped   = out_reg.scan_stopped;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot filled with output register empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        par_valid |-> !skid_valid_reg)
        else $error("new result with queue full");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule

### bench/fdes_result_checker.sv
`timescale 1ns / 1ps
// fdes_result_checker: watches the byte, result and config channels of the scanner,
// predicts each directory result and compares it with what the block delivers
// depends on fdes_pkg
module fdes_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic                        byte_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        scan_start,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic                        kind,
    input  logic [63:0]                 name_head,
    input  logic [23:0]                 name_tail,
    input  logic [7:0]                  attribute_bits,
    input  logic [31:0]                 first_cluster,
    input  logic [31:0]                 file_size,
    input  logic                        name_matches,
    input  logic                        scan_stopped,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdes_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          results_due
);

    // mirrored configuration
    logic [63:0] want_head;
    logic [23:0] want_tail;
    logic        find_first;

    // mirrored scan state
    logic [fdes_pkg::POS_W-1:0] at_pos;
    logic                       halted;
    logic                       skip_entry;
    fdes_pkg::name_bytes_t      name_buf;
    logic [7:0]                 attr_buf;
    logic [15:0]                clus_hi_buf;
    logic [15:0]                clus_lo_buf;
    logic [31:0]                size_buf;

    fdes_pkg::result_t entries_due[$];
    int                fail_n;

    task automatic parse_dir_byte(input logic [7:0] b, input logic restart);
        fdes_pkg::result_t r;
        logic [87:0]       name_flat;
        logic              hit;
        int                sh;
        if (restart)
        begin
            at_pos = fdes_pkg::POS_FIRST;
            halted = 1'b0;
        end
        if (!halted)
        begin
            if (at_pos == fdes_pkg::POS_FIRST)
            begin
                skip_entry = (b == fdes_pkg::MARK_DELETED);
                if (b == fdes_pkg::MARK_END)
                begin
                    halted = 1'b1;
                    skip_entry = 1'b1;
                    r = '0;
                    r.kind = fdes_pkg::KIND_END;
                    r.scan_stopped = 1'b1;
                    entries_due.push_back(r);
                end
            end
            if (!skip_entry)
            begin
                if (at_pos < fdes_pkg::NAME_BYTES)
                    name_buf[at_pos] = b;
                else if (at_pos == fdes_pkg::POS_ATTR)
                begin
                    attr_buf = b;
                    skip_entry = (b == fdes_pkg::ATTR_LONG_NAME);
                end
                else if (at_pos == fdes_pkg::POS_CLUS_HI_0)
                    clus_hi_buf[7:0] = b;
                else if (at_pos == fdes_pkg::POS_CLUS_HI_1)
                    clus_hi_buf[15:8] = b;
                else if (at_pos == fdes_pkg::POS_CLUS_LO_0)
                    clus_lo_buf[7:0] = b;
                else if (at_pos == fdes_pkg::POS_CLUS_LO_1)
                    clus_lo_buf[15:8] = b;
                else if (at_pos >= fdes_pkg::POS_SIZE_0)
                begin
                    sh = 8 * (int'(at_pos) - int'(fdes_pkg::POS_SIZE_0));
                    size_buf[sh +: 8] = b;
                end

                if (at_pos == fdes_pkg::POS_LAST)
                begin
                    name_flat = name_buf;
                    hit = (name_flat == {want_tail, want_head});
                    if (hit && find_first)
                        halted = 1'b1;
                    r.kind = fdes_pkg::KIND_ENTRY;
                    r.name_head = name_flat[63:0];
                    r.name_tail = name_flat[87:64];
                    r.attribute_bits = attr_buf;
                    r.first_cluster = {clus_hi_buf, clus_lo_buf};
                    r.file_size = size_buf;
                    r.name_matches = hit;
                    r.scan_stopped = halted;
                    entries_due.push_back(r);
                end
            end
            // wraps from the last byte back to the first
            at_pos = at_pos + 1'b1;
        end
    endtask

    task automatic check_dir_result();
        fdes_pkg::result_t want;
        logic              bad;
        if (entries_due.size() == 0)
        begin
            fail_n++;
            if (fail_n <= 10)
                $display("%t: result with nothing expected: kind %0d head %h tail %h",
                         $realtime, kind, name_head, name_tail);
        end
        else
        begin
            want = entries_due.pop_front();
            bad = (kind !== want.kind) || (name_head !== want.name_head)
                || (name_tail !== want.name_tail)
                || (attribute_bits !== want.attribute_bits)
                || (first_cluster !== want.first_cluster)
                || (file_size !== want.file_size)
                || (name_matches !== want.name_matches)
                || (scan_stopped !== want.scan_stopped);
            if (bad)
            begin
                fail_n++;
                if (fail_n <= 10)
                    $display({"%t: result mismatch (expected/actual): kind %0d/%0d ",
                              "head %h/%h tail %h/%h attr %h/%h cluster %h/%h ",
                              "size %h/%h match %0d/%0d stopped %0d/%0d"},
                             $realtime, want.kind, kind, want.name_head, name_head,
                             want.name_tail, name_tail, want.attribute_bits,
                             attribute_bits, want.first_cluster, first_cluster,
                             want.file_size, file_size, want.name_matches, name_matches,
                             want.scan_stopped, scan_stopped);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_head = '0;
            want_tail = '0;
            find_first = 1'b0;
            at_pos = fdes_pkg::POS_FIRST;
            halted = 1'b0;
            skip_entry = 1'b0;
            name_buf = '0;
            attr_buf = '0;
            clus_hi_buf = '0;
            clus_lo_buf = '0;
            size_buf = '0;
            entries_due.delete();
            fail_n = 0;
            fail_count <= 0;
            results_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[fdes_pkg::ADDR_W-1:3])
                    fdes_pkg::REG_TARGET_HEAD: want_head = pwdata;
                    fdes_pkg::REG_TARGET_TAIL: want_tail = pwdata[23:0];
                    fdes_pkg::REG_FIND_MODE:   find_first = pwdata[0];
                    default: ;
                endcase
            end
            // a result always trails its byte, so check before predicting
            if (result_valid && !result_stall)
                check_dir_result();
            if (byte_valid && !byte_stall)
                parse_dir_byte(data_byte, scan_start);
            fail_count <= fail_n;
            results_due <= entries_due.size();
        end
    end

endmodule

### bench/fat_directory_entry_scanner_tb.sv
`timescale 1ns / 1ps
// fat_directory_entry_scanner_tb: drives directory byte streams and config writes
// into the scanner, with random idling on both sides; depends on fdes_pkg,
// fat_directory_entry_scanner and fdes_result_checker
module fat_directory_entry_scanner_tb;

    localparam int HOLD_OFF_CYCLES = 90;
    localparam int QUIET_LIMIT     = 3000;

    logic clk;
    logic rst_n = 1'b0;

    logic                        byte_valid   = 1'b0;
    logic                        byte_stall;
    logic [7:0]                  data_byte    = '0;
    logic                        scan_start   = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic                        kind;
    logic [63:0]                 name_head;
    logic [23:0]                 name_tail;
    logic [7:0]                  attribute_bits;
    logic [31:0]                 first_cluster;
    logic [31:0]                 file_size;
    logic                        name_matches;
    logic                        scan_stopped;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [fdes_pkg::ADDR_W-1:0] paddr        = '0;
    logic [63:0]                 pwdata       = '0;
    logic [63:0]                 prdata;
    logic                        pready;

    int fail_count;
    int results_due;

    // stimulus bookkeeping
    fdes_pkg::name_bytes_t tgt;
    logic                  find_on      = 1'b0;
    logic                  resync       = 1'b1;
    logic                  steady       = 1'b0;
    int                    items_sent   = 0;
    int                    results_seen = 0;
    int                    hold_token   = 0;
    int                    hold_seen;
    int                    hold_left;
    int                    quiet_cycles = 0;

    fat_directory_entry_scanner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .scan_start     (scan_start),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .name_head      (name_head),
        .name_tail      (name_tail),
        .attribute_bits (attribute_bits),
        .first_cluster  (first_cluster),
        .file_size      (file_size),
        .name_matches   (name_matches),
        .scan_stopped   (scan_stopped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    fdes_result_checker results_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .scan_start     (scan_start),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .name_head      (name_head),
        .name_tail      (name_tail),
        .attribute_bits (attribute_bits),
        .first_cluster  (first_cluster),
        .file_size      (file_size),
        .name_matches   (name_matches),
        .scan_stopped   (scan_stopped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls unless steady, long hold-off when the token moves
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                results_seen <= results_seen + 1;
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !steady && ($urandom_range(99) < 38);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall)
                || (psel && penable && pwrite && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL fat_directory_entry_scanner");
                $finish;
            end
        end
    end

    function automatic fdes_pkg::name_bytes_t random_name(input bit any_first);
        fdes_pkg::name_bytes_t nm;
        for (int i = 0; i < fdes_pkg::NAME_BYTES; i++)
            nm[i] = 8'($urandom);
        // keep a plain entry from turning into a deleted or end marker
        if (!any_first && (nm[0] == fdes_pkg::MARK_END || nm[0] == fdes_pkg::MARK_DELETED))
            nm[0] = nm[0] ^ 8'h80;
        return nm;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic st, input bit live);
        while (!steady && $urandom_range(99) < 38)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        scan_start <= st;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (live)
            items_sent++;
    endtask

    task automatic send_dir_entry(input fdes_pkg::name_bytes_t nm, input logic [7:0] attr,
                                  input logic [31:0] clus, input logic [31:0] fsize,
                                  input int upto);
        logic [7:0] raw [32];
        logic       st;
        bit         ends;
        for (int i = 0; i < 32; i++)
            raw[i] = 8'($urandom);
        for (int i = 0; i < fdes_pkg::NAME_BYTES; i++)
            raw[i] = nm[i];
        raw[fdes_pkg::POS_ATTR] = attr;
        raw[fdes_pkg::POS_CLUS_HI_0] = clus[23:16];
        raw[fdes_pkg::POS_CLUS_HI_1] = clus[31:24];
        raw[fdes_pkg::POS_CLUS_LO_0] = clus[7:0];
        raw[fdes_pkg::POS_CLUS_LO_1] = clus[15:8];
        for (int i = 0; i < 4; i++)
            raw[fdes_pkg::POS_SIZE_0 + i] = fsize[8*i +: 8];
        st = resync || ($urandom_range(99) < 5);
        resync = 1'b0;
        // the end marker stops the scan at once, the rest of its entry is moot
        if (nm[0] == fdes_pkg::MARK_END)
            upto = 1;
        for (int i = 0; i < upto; i++)
            push_byte(raw[i], (i == 0) ? st : 1'b0, 1'b1);
        ends = (nm[0] == fdes_pkg::MARK_END)
            || (upto == 32 && find_on && nm == tgt && nm[0] != fdes_pkg::MARK_DELETED
                && attr != fdes_pkg::ATTR_LONG_NAME);
        // a few bytes the stopped scan must ignore
        if (ends)
            repeat ($urandom_range(3))
                push_byte(8'($urandom), 1'b0, 1'b0);
        if (ends || upto < 32)
            resync = 1'b1;
    endtask

    task automatic noise_burst(input int n);
        repeat (n)
            push_byte(8'($urandom), $urandom_range(9) == 0, 1'b1);
        resync = 1'b1;
    endtask

    task automatic wait_drained(input int settle);
        byte_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [fdes_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_target(input fdes_pkg::name_bytes_t t, input logic fm);
        logic [87:0] flat;
        flat = t;
        wait_drained(4);
        write_reg(fdes_pkg::REG_TARGET_HEAD, flat[63:0]);
        write_reg(fdes_pkg::REG_TARGET_TAIL, {40'd0, flat[87:64]});
        write_reg(fdes_pkg::REG_FIND_MODE, {63'd0, fm});
        tgt = t;
        find_on = fm;
    endtask

    // every byte starts a fresh scan on an end marker, one result per byte
    task automatic end_marker_flood();
        hold_token <= hold_token + 1;
        repeat (24)
            push_byte(fdes_pkg::MARK_END, 1'b1, 1'b1);
        resync = 1'b1;
    endtask

    task automatic random_traffic(input int item_goal, input int result_goal);
        int                    roll;
        fdes_pkg::name_bytes_t nm;
        bit                    can_match;
        can_match = (tgt[0] != fdes_pkg::MARK_END) && (tgt[0] != fdes_pkg::MARK_DELETED);
        while (items_sent < item_goal || results_seen < result_goal)
        begin
            roll = $urandom_range(99);
            nm = random_name(1'b0);
            if (roll < 45)
                send_dir_entry(nm, 8'($urandom), $urandom, $urandom, 32);
            else if (roll < 57)
                send_dir_entry(can_match ? tgt : nm, 8'($urandom), $urandom, $urandom, 32);
            else if (roll < 65)
            begin
                nm[0] = fdes_pkg::MARK_DELETED;
                send_dir_entry(nm, 8'($urandom), $urandom, $urandom, 32);
            end
            else if (roll < 73)
                send_dir_entry(nm, fdes_pkg::ATTR_LONG_NAME, $urandom, $urandom, 32);
            else if (roll < 80)
            begin
                nm[0] = fdes_pkg::MARK_END;
                send_dir_entry(nm, 8'($urandom), $urandom, $urandom, 32);
            end
            else if (roll < 88)
                send_dir_entry(nm, 8'($urandom), $urandom, $urandom,
                               $urandom_range(31, 1));
            else if (roll < 96)
                noise_burst($urandom_range(40, 1));
            else
                wait_drained(0);
        end
    endtask

    initial
    begin
        fdes_pkg::name_bytes_t nm;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // list mode: extremes, a match, deleted, long name, restart, end of directory
        set_target(random_name(1'b0), 1'b0);
        send_dir_entry('1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32);
        send_dir_entry(tgt, 8'h00, 32'd0, 32'd0, 32);
        nm = random_name(1'b0);
        nm[0] = fdes_pkg::MARK_DELETED;
        send_dir_entry(nm, 8'h20, $urandom, $urandom, 32);
        send_dir_entry(random_name(1'b0), fdes_pkg::ATTR_LONG_NAME, $urandom, $urandom, 32);
        send_dir_entry(random_name(1'b0), 8'h10, $urandom, $urandom, 12);
        send_dir_entry(random_name(1'b0), 8'h10, $urandom, $urandom, 32);
        nm[0] = fdes_pkg::MARK_END;
        send_dir_entry(nm, 8'h00, 32'd0, 32'd0, 32);

        // find mode with an all-ones target: a match stops the scan
        set_target('1, 1'b1);
        send_dir_entry('1, 8'h01, $urandom, $urandom, 32);
        send_dir_entry(random_name(1'b0), 8'h20, $urandom, $urandom, 32);
        random_traffic(250, 15);

        // all-zero target never matches a live entry
        set_target('0, 1'b0);
        end_marker_flood();
        random_traffic(450, 25);

        steady <= 1'b1;
        set_target(random_name(1'b1), 1'b1);
        random_traffic(600, 40);
        steady <= 1'b0;

        set_target(random_name(1'b0), 1'b0);
        random_traffic(800, 60);

        wait_drained(8);
        if (fail_count == 0 && results_due == 0)
            $display("PASS fat_directory_entry_scanner");
        else
            $display("FAIL fat_directory_entry_scanner");
        $finish;
    end

endmodule

### files.f
src/fdes_pkg.sv
src/fdes_entry_parse.sv
src/fat_directory_entry_scanner.sv
bench/fdes_result_checker.sv
bench/fat_directory_entry_scanner_tb.sv
